/* hw/rtl/tksel_pkg.sv */
`timescale 1ns / 1ps
package tksel_pkg;

  localparam int SCORE_W = 32;
  localparam int ID_W    = 64;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam int KEEP_W  = 6;
  localparam int RANK_W  = 5;

  localparam logic [SCORE_W-1:0] MINUS_INF  = 32'h8000_0000;
  localparam logic [SCORE_W-1:0] SCORE_BIAS = 32'h8000_0000;
  localparam logic [ID_W-1:0]    ID_BIAS    = 64'h8000_0000_0000_0000;
  localparam logic [ID_W-1:0]    EMPTY_ID   = '1;
  localparam logic [KEEP_W-1:0]  KEEP_RST   = 6'd10;

  // Register index of keep_count (paddr[2])
  localparam logic REG_KEEP = 1'b0;

  typedef enum logic [1:0] {
    FN_PUSH  = 2'd0,
    FN_READ  = 2'd1,
    FN_CLEAR = 2'd2
  } func_t;

  // Sub-steps of one entry visit during a scan
  typedef enum logic [1:0] {
    PH_ADDR = 2'd0,
    PH_CMP  = 2'd1,
    PH_SEL  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_WORST,
    S_SORT,
    S_EMIT,
    S_REPLY
  } state_t;

endpackage

/* hw/rtl/top_k_score_selector_core.sv */
`timescale 1ns / 1ps
// Channel   Handshake                     Payload
// input     start / busy                  in_func, in_item_id, in_item_score
// result    out_valid (1-cycle strobe)    out_res_id, out_res_score, out_res_rank,
//                                         out_res_last, out_threshold_score,
//                                         out_kept_count
// config    APB psel/penable/pwrite       paddr, pwdata, prdata, pready (always 1)
//
// Operation: all work goes through one key comparator and an entry memory with
// one write port and a registered read port, visiting entries one at a time in
// address and compare phases (worst scan) or address, compare and select phases
// (sorted readout). Clear and a push while filling are answered directly; a push
// that fills the store or replaces the worst entry runs a worst scan first; a
// rejected push on a full store is answered directly. A readout runs one
// selection pass per occupied rank and emits each empty rank without a scan.
// Reset: synchronous, active low; store empty, keep_count = 10. Entry memory
// is not cleared; the fill count alone marks valid entries.
// The result receiver cannot stall; busy holds off new transactions until the
// last result of the current one has been strobed.
module top_k_score_selector_core #(
  parameter int K_MAX = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input transactions
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_func,
  input  logic signed [tksel_pkg::ID_W-1:0]   in_item_id,
  input  logic signed [tksel_pkg::SCORE_W-1:0] in_item_score,
  // results
  output logic                                out_valid,
  output logic signed [tksel_pkg::ID_W-1:0]   out_res_id,
  output logic signed [tksel_pkg::SCORE_W-1:0] out_res_score,
  output logic [tksel_pkg::RANK_W-1:0]        out_res_rank,
  output logic                                out_res_last,
  output logic signed [tksel_pkg::SCORE_W-1:0] out_threshold_score,
  output logic [tksel_pkg::KEEP_W-1:0]        out_kept_count,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tksel_pkg::CFG_AW-1:0]        paddr,
  input  logic [tksel_pkg::CFG_DW-1:0]        pwdata,
  output logic [tksel_pkg::CFG_DW-1:0]        prdata,
  output logic                                pready
);
  import tksel_pkg::*;

  localparam int IDX_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int CNT_W = $clog2(K_MAX + 1);
  localparam int CW    = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;
  // Sort key: biased score, inverted biased id, inverted index. Larger = better.
  localparam int KEY_W = SCORE_W + ID_W + IDX_W;

  // Entry store
  logic [SCORE_W-1:0] mem_score [K_MAX];
  logic [ID_W-1:0]    mem_id    [K_MAX];
  logic [SCORE_W-1:0] rd_score_r;
  logic [ID_W-1:0]    rd_id_r;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;

  state_t             state_r, state_nxt;
  phase_t             ph_r, ph_nxt;
  logic [KEEP_W-1:0]  keep_r;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [CNT_W-1:0]   rank_r, rank_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   wi_r, wi_nxt;
  logic [KEY_W-1:0]   wk_r, wk_nxt;
  logic [KEY_W-1:0]   pk_r, pk_nxt;
  logic [KEY_W-1:0]   bk_r, bk_nxt;
  logic               bf_r, bf_nxt;
  logic               lt_r, lt_nxt;
  logic [ID_W-1:0]    it_id_r;
  logic [SCORE_W-1:0] it_sc_r;

  logic [CNT_W-1:0]   k_eff;
  logic               accept;
  logic               cfg_wr;
  logic               full;
  logic               last_entry;
  logic [KEY_W-1:0]   cand_key, new_key;
  logic [KEY_W-1:0]   cmp_a, cmp_b;
  logic               cmp_gt;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_KEEP) ? CFG_DW'(keep_r) : '0;

  // Effective count saturates at K_MAX
  assign k_eff = (CW'(keep_r) >= CW'(K_MAX)) ? CNT_W'(K_MAX) : CNT_W'(keep_r);
  assign full  = (k_eff != '0) && (fill_r == k_eff);

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // ---------------- shared comparator ----------------
  // Read data belongs to idx_r once past the address phase.
  assign cand_key = {rd_score_r ^ SCORE_BIAS, ~(rd_id_r ^ ID_BIAS), ~idx_r};
  // New item borrows the worst entry's index bits: ties are not "better".
  assign new_key  = {it_sc_r ^ SCORE_BIAS, ~(it_id_r ^ ID_BIAS), wk_r[IDX_W-1:0]};

  always_comb begin
    unique case (state_r)
      S_PUSH: begin
        cmp_a = new_key;
        cmp_b = wk_r;
      end
      S_SORT: begin
        if (ph_r == PH_CMP) begin
          cmp_a = pk_r;
          cmp_b = cand_key;
        end else begin
          cmp_a = cand_key;
          cmp_b = bk_r;
        end
      end
      default: begin
        cmp_a = wk_r;
        cmp_b = cand_key;
      end
    endcase
  end

  assign cmp_gt     = (cmp_a > cmp_b);
  assign last_entry = ((CW'(idx_r) + CW'(1)) == CW'(fill_r));

  // ---------------- entry memory ----------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_score[mem_waddr] <= it_sc_r;
      mem_id[mem_waddr]    <= it_id_r;
    end
    rd_score_r <= mem_score[idx_r];
    rd_id_r    <= mem_id[idx_r];
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= PH_ADDR;
      keep_r  <= KEEP_RST;
      fill_r  <= '0;
      rank_r  <= '0;
      idx_r   <= '0;
      bf_r    <= 1'b0;
      lt_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      rank_r  <= rank_nxt;
      idx_r   <= idx_nxt;
      bf_r    <= bf_nxt;
      lt_r    <= lt_nxt;
      if (cfg_wr && (paddr[2] == REG_KEEP)) begin
        keep_r <= pwdata[KEEP_W-1:0];
        fill_r <= '0;                     // new keep_count starts an empty store
      end else begin
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    wi_r <= wi_nxt;
    wk_r <= wk_nxt;
    pk_r <= pk_nxt;
    bk_r <= bk_nxt;
    if (accept) begin
      it_id_r <= in_item_id;
      it_sc_r <= in_item_score;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    fill_nxt  = fill_r;
    rank_nxt  = rank_r;
    idx_nxt   = idx_r;
    wi_nxt    = wi_r;
    wk_nxt    = wk_r;
    pk_nxt    = pk_r;
    bk_nxt    = bk_r;
    bf_nxt    = bf_r;
    lt_nxt    = lt_r;
    mem_we    = 1'b0;
    mem_waddr = (fill_r < k_eff) ? IDX_W'(fill_r) : wi_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_func)
            FN_PUSH: state_nxt = S_PUSH;
            FN_READ: begin
              rank_nxt = '0;
              idx_nxt  = '0;
              ph_nxt   = PH_ADDR;
              bf_nxt   = 1'b0;
              if (k_eff != '0) begin
                state_nxt = (fill_r != '0) ? S_SORT : S_EMIT;
              end
            end
            FN_CLEAR: begin
              fill_nxt  = '0;
              state_nxt = S_REPLY;
            end
            default: state_nxt = S_IDLE;  // unused code: dropped
          endcase
        end
      end

      S_PUSH: begin
        idx_nxt = '0;
        ph_nxt  = PH_ADDR;
        if (k_eff == '0) begin
          state_nxt = S_REPLY;
        end else if (fill_r < k_eff) begin
          mem_we    = 1'b1;
          fill_nxt  = fill_r + CNT_W'(1);
          // store just became full: find its worst entry
          state_nxt = (fill_r + CNT_W'(1) == k_eff) ? S_WORST : S_REPLY;
        end else if (cmp_gt) begin
          mem_we    = 1'b1;               // evict current worst
          state_nxt = S_WORST;
        end else begin
          state_nxt = S_REPLY;
        end
      end

      // Linear scan for the worst kept entry; result held in wk_r/wi_r
      S_WORST: begin
        if (ph_r == PH_ADDR) begin
          ph_nxt = PH_CMP;
        end else begin
          if ((idx_r == '0) || cmp_gt) begin
            wk_nxt = cand_key;
            wi_nxt = idx_r;
          end
          ph_nxt = PH_ADDR;
          if (last_entry) begin
            state_nxt = S_REPLY;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end

      // Selection pass: best entry strictly below the previously emitted key
      S_SORT: begin
        unique case (ph_r)
          PH_ADDR: ph_nxt = PH_CMP;
          PH_CMP: begin
            lt_nxt = (rank_r == '0) || cmp_gt;
            ph_nxt = PH_SEL;
          end
          default: begin
            if (lt_r && (!bf_r || cmp_gt)) begin
              bk_nxt = cand_key;
              bf_nxt = 1'b1;
            end
            ph_nxt = PH_ADDR;
            if (last_entry) begin
              state_nxt = S_EMIT;
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
            end
          end
        endcase
      end

      S_EMIT: begin
        pk_nxt   = bk_r;
        rank_nxt = rank_r + CNT_W'(1);
        idx_nxt  = '0;
        ph_nxt   = PH_ADDR;
        bf_nxt   = 1'b0;
        if (rank_r + CNT_W'(1) == k_eff) begin
          state_nxt = S_IDLE;
        end else if (rank_r + CNT_W'(1) < fill_r) begin
          state_nxt = S_SORT;
        end else begin
          state_nxt = S_EMIT;             // remaining ranks are empty slots
        end
      end

      S_REPLY: state_nxt = S_IDLE;

      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------- result port ----------------
  always_comb begin
    out_valid           = 1'b0;
    out_res_id          = '0;
    out_res_score       = '0;
    out_res_rank        = '0;
    out_res_last        = 1'b0;
    out_threshold_score = full ? (wk_r[KEY_W-1 -: SCORE_W] ^ SCORE_BIAS) : MINUS_INF;
    out_kept_count      = KEEP_W'(fill_r);
    case (state_r)
      S_EMIT: begin
        out_valid    = 1'b1;
        out_res_rank = RANK_W'(rank_r);
        out_res_last = (rank_r + CNT_W'(1) == k_eff);
        if (rank_r < fill_r) begin
          out_res_id    = ~bk_r[KEY_W-SCORE_W-1 -: ID_W] ^ ID_BIAS;
          out_res_score = bk_r[KEY_W-1 -: SCORE_W] ^ SCORE_BIAS;
        end else begin
          out_res_id    = EMPTY_ID;
          out_res_score = MINUS_INF;
        end
      end
      S_REPLY: begin
        out_valid    = 1'b1;
        out_res_last = 1'b1;
      end
      default: out_valid = 1'b0;
    endcase
  end

  // ---------------- assertions ----------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= k_eff)
    else $error("fill count above effective keep_count");

  a_more_results: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res_last) |=> busy)
    else $error("block went idle before last result");

  a_sort_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && rank_r < fill_r) |-> bf_r)
    else $error("selection pass found no entry for occupied rank");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FN_CLEAR) |=> (fill_r == '0 && state_r == S_REPLY))
    else $error("clear did not empty the store");

endmodule

/* dv/top_k_score_selector_core_tb.sv */
`timescale 1ns / 1ps
module top_k_score_selector_core_tb;
  import tksel_pkg::*;

  localparam int SLOTS = 32;  // K_MAX of the instance

  // Unused func code: the block must swallow it without a result
  localparam logic [1:0] FN_UNUSED = 2'd3;
  // keep_count sits at register index REG_KEEP, byte address 4 * index
  localparam logic [CFG_AW-1:0] KEEP_ADDR = {REG_KEEP, 2'b00};

  localparam logic signed [ID_W-1:0]    ID_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ID_W-1:0]    ID_MIN      = 64'sh8000_0000_0000_0000;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [SCORE_W-1:0] SCORE_FLOOR = 32'sh8000_0001;

  // One result transaction as seen on the out_ ports
  typedef struct packed {
    logic signed [ID_W-1:0]    id;
    logic signed [SCORE_W-1:0] score;
    logic [RANK_W-1:0]         rank;
    logic                      last;
    logic signed [SCORE_W-1:0] thresh;
    logic [KEEP_W-1:0]         kept;
  } ranked_result_t;

  // Mirror of the kept set plus the queue of results still owed by the block.
  class best_k_tracker;
    logic signed [SCORE_W-1:0] kept_score[SLOTS];
    logic signed [ID_W-1:0]    kept_id[SLOTS];
    int fill;
    int keep;
    ranked_result_t owed_results[$];
    int errors;
    int results_seen;
    int pushes, readouts, clears, ignored, cfg_writes;

    function new();
      fill = 0;
      keep = KEEP_RST;
      errors = 0;
      results_seen = 0;
      pushes = 0; readouts = 0; clears = 0; ignored = 0; cfg_writes = 0;
    endfunction

    function int eff_keep();
      return (keep < SLOTS) ? keep : SLOTS;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    // higher score wins, lower id breaks ties
    function bit ranks_above(input logic signed [SCORE_W-1:0] sa,
                             input logic signed [ID_W-1:0] ia,
                             input logic signed [SCORE_W-1:0] sb,
                             input logic signed [ID_W-1:0] ib);
      if (sa != sb) return sa > sb;
      return ia < ib;
    endfunction

    function int worst_slot();
      int w;
      w = 0;
      for (int i = 1; i < fill; i++)
        if (ranks_above(kept_score[w], kept_id[w], kept_score[i], kept_id[i])) w = i;
      return w;
    endfunction

    function logic signed [SCORE_W-1:0] cutoff();
      if (eff_keep() == 0 || fill < eff_keep()) return MINUS_INF;
      return kept_score[worst_slot()];
    endfunction

    function void owe(input logic signed [ID_W-1:0] id,
                      input logic signed [SCORE_W-1:0] sc,
                      input int rank, input bit last);
      ranked_result_t r;
      r.id     = id;
      r.score  = sc;
      r.rank   = rank[RANK_W-1:0];
      r.last   = last;
      r.thresh = cutoff();
      r.kept   = fill[KEEP_W-1:0];
      owed_results = {owed_results, r};
    endfunction

    // writing keep_count also empties the store
    function void set_keep(input int value);
      keep = value & 63;
      fill = 0;
      cfg_writes++;
    endfunction

    function void accept_transaction(input logic [1:0] fn,
                                     input logic signed [ID_W-1:0] id,
                                     input logic signed [SCORE_W-1:0] sc);
      logic signed [SCORE_W-1:0] ss[SLOTS];
      logic signed [ID_W-1:0]    si[SLOTS];
      logic signed [SCORE_W-1:0] s;
      logic signed [ID_W-1:0]    d;
      int k, n, j, w;
      k = eff_keep();
      if (fn == FN_PUSH) begin
        pushes++;
        if (k != 0) begin
          if (fill < k) begin
            kept_score[fill] = sc;
            kept_id[fill] = id;
            fill++;
          end else begin
            w = worst_slot();
            if (ranks_above(sc, id, kept_score[w], kept_id[w])) begin
              kept_score[w] = sc;
              kept_id[w] = id;
            end
          end
        end
        owe('0, '0, 0, 1'b1);
      end else if (fn == FN_READ) begin
        readouts++;
        n = (fill < k) ? fill : k;
        // stable insertion sort, best first
        for (int i = 0; i < n; i++) begin
          s = kept_score[i];
          d = kept_id[i];
          j = i;
          while (j > 0 && ranks_above(s, d, ss[j-1], si[j-1])) begin
            ss[j] = ss[j-1];
            si[j] = si[j-1];
            j--;
          end
          ss[j] = s;
          si[j] = d;
        end
        for (int i = 0; i < k; i++) begin
          if (i < n) owe(si[i], ss[i], i, i + 1 == k);
          else owe(EMPTY_ID, MINUS_INF, i, i + 1 == k);
        end
      end else if (fn == FN_CLEAR) begin
        clears++;
        fill = 0;
        owe('0, '0, 0, 1'b1);
      end else begin
        ignored++;
      end
    endfunction

    function void compare_result(input ranked_result_t got);
      ranked_result_t exp;
      results_seen++;
      if (owed_results.size() == 0) begin
        flag($sformatf("unexpected result: id=%0d score=%h rank=%0d last=%0b thr=%h kept=%0d",
                       got.id, got.score, got.rank, got.last, got.thresh, got.kept));
        return;
      end
      exp = owed_results.pop_front();
      if (got !== exp)
        flag($sformatf({"result mismatch at %0t:\n",
                        "  expected id=%0d score=%h rank=%0d last=%0b thr=%h kept=%0d\n",
                        "  actual   id=%0d score=%h rank=%0d last=%0b thr=%h kept=%0d"},
                       $time, exp.id, exp.score, exp.rank, exp.last, exp.thresh, exp.kept,
                       got.id, got.score, got.rank, got.last, got.thresh, got.kept));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_func;
  logic signed [ID_W-1:0] in_item_id;
  logic signed [SCORE_W-1:0] in_item_score;
  logic out_valid;
  logic signed [ID_W-1:0] out_res_id;
  logic signed [SCORE_W-1:0] out_res_score;
  logic [RANK_W-1:0] out_res_rank;
  logic out_res_last;
  logic signed [SCORE_W-1:0] out_threshold_score;
  logic [KEEP_W-1:0] out_kept_count;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  best_k_tracker tracker = new();

  top_k_score_selector_core #(.K_MAX(SLOTS)) uut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_func(in_func), .in_item_id(in_item_id), .in_item_score(in_item_score),
    .out_valid(out_valid), .out_res_id(out_res_id), .out_res_score(out_res_score),
    .out_res_rank(out_res_rank), .out_res_last(out_res_last),
    .out_threshold_score(out_threshold_score), .out_kept_count(out_kept_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: stops a hung run and reports it as completed with errors.
  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result monitor: strobe cannot be held off, so every valid cycle is
  // one transaction, sampled at the edge that closes it.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      tracker.compare_result({out_res_id, out_res_score, out_res_rank, out_res_last,
                              out_threshold_score, out_kept_count});
  end

  // Called at a clock edge. Holds start high until the block takes the
  // transaction; start is left high so a back-to-back call keeps it up.
  task automatic send_item(input logic [1:0] fn, input logic signed [ID_W-1:0] id,
                           input logic signed [SCORE_W-1:0] sc);
    start         <= 1'b1;
    in_func       <= fn;
    in_item_id    <= id;
    in_item_score <= sc;
    do @(posedge clk); while (busy);
    tracker.accept_transaction(fn, id, sc);
  endtask

  // Drop start and hold until all owed results are out. Always waits on the
  // clock before returning, so start never sees two updates in one step.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // Drain, then cover transactions that end silently (unused code, readout with
  // keep_count zero) before touching the register.
  task automatic settle();
    drain();
    repeat (10) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // APB write of keep_count followed by a read-back.
  task automatic write_keep(input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KEEP_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_keep(value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DW'(value & 63))
      tracker.flag($sformatf("keep_count read-back: expected %0d, got %0d",
                             value & 63, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Scores: small values force ties, plus the extremes and minus infinity.
  function automatic logic signed [SCORE_W-1:0] pick_score();
    int r;
    r = $urandom_range(99);
    if (r < 40) return $signed(SCORE_W'($urandom_range(8))) - 4;
    if (r < 52) begin
      case ($urandom_range(2))
        0: return MINUS_INF;
        1: return SCORE_FLOOR;
        default: return SCORE_MAX;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic signed [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 40) return $signed(ID_W'($urandom_range(8))) - 4;
    if (r < 50) begin
      case ($urandom_range(2))
        0: return ID_MIN;
        1: return ID_MAX;
        default: return EMPTY_ID;
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  // Random plan: one keep_count setting and one sender idle rate per phase.
  // Keep values include both extremes and the saturating 63.
  int keep_plan[8] = '{4, 32, 1, 63, 0, 9, 2, 0};
  int idle_plan[8] = '{0, 59, 32, 0, 59, 32, 0, 59};

  initial begin
    int n_items, r;
    logic [1:0] fn;
    start         <= 1'b0;
    in_func       <= FN_PUSH;
    in_item_id    <= '0;
    in_item_score <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst_n         <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset keep_count of 10: empty readout, field extremes,
    // minus infinity, tie on score, exact duplicate, unused code, clear.
    send_item(FN_READ, '0, '0);
    send_item(FN_PUSH, ID_MAX, SCORE_MAX);
    send_item(FN_PUSH, ID_MIN, SCORE_FLOOR);
    send_item(FN_PUSH, '0, MINUS_INF);
    send_item(FN_PUSH, EMPTY_ID, '0);
    send_item(FN_PUSH, -64'sd5, '0);
    send_item(FN_PUSH, -64'sd5, '0);
    send_item(FN_READ, '0, '0);
    send_item(FN_UNUSED, ID_MAX, SCORE_MAX);
    send_item(FN_CLEAR, '0, '0);
    send_item(FN_READ, '0, '0);

    // Store of two: fill, reject worse id, duplicate of a kept entry replaces the
    // worst, replace worst, reject minus infinity.
    settle();
    write_keep(2);
    send_item(FN_PUSH, 64'sd7, 32'sd100);
    send_item(FN_PUSH, 64'sd3, 32'sd100);
    send_item(FN_PUSH, 64'sd9, 32'sd100);
    send_item(FN_PUSH, 64'sd3, 32'sd100);
    send_item(FN_PUSH, 64'sd2, 32'sd100);
    send_item(FN_PUSH, 64'sd1, MINUS_INF);
    send_item(FN_READ, '0, '0);

    // keep_count zero: push ignored but answered, readout silent.
    settle();
    write_keep(0);
    send_item(FN_PUSH, 64'sd1, 32'sd5);
    send_item(FN_READ, '0, '0);
    send_item(FN_CLEAR, '0, '0);

    keep_plan[7] = $urandom_range(3, 40);
    for (int p = 0; p < 8; p++) begin
      settle();
      write_keep(keep_plan[p]);
      n_items = (keep_plan[p] == 0) ? 20 : 42;
      for (int i = 0; i < n_items; i++) begin
        if (idle_plan[p] > 0 && $urandom_range(99) < idle_plan[p]) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end else if ($urandom_range(99) < 3) begin
          drain();
        end
        r = $urandom_range(99);
        if (r < 78) fn = FN_PUSH;
        else if (r < 88) fn = FN_READ;
        else if (r < 95) fn = FN_CLEAR;
        else fn = FN_UNUSED;
        send_item(fn, pick_id(), pick_score());
      end
    end

    // Explicit full drain once more, then tail for silent transactions.
    drain();
    repeat (50) @(posedge clk);
    while (tracker.pending() != 0) begin
      tracker.flag("expected result never arrived");
      void'(tracker.owed_results.pop_front());
    end

    $display("Run covered %0d pushes, %0d readouts, %0d clears, %0d unused codes",
             tracker.pushes, tracker.readouts, tracker.clears, tracker.ignored);
    $display("  %0d results checked over %0d keep_count writes (0 to 63); %0d errors",
             tracker.results_seen, tracker.cfg_writes, tracker.errors);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/tksel_pkg.sv
hw/rtl/top_k_score_selector_core.sv
dv/top_k_score_selector_core_tb.sv
